### hdl/masked_byte_pattern_search_core_defines.svh
// Assertion macros shared by the pattern search checker.
`ifndef MASKED_BYTE_PATTERN_SEARCH_CORE_DEFINES_SVH
`define MASKED_BYTE_PATTERN_SEARCH_CORE_DEFINES_SVH

// Same-cycle implication, off while rst_n is low.
`define MBPS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mbps same-cycle check failed");

// Next-cycle implication, off while rst_n is low.
`define MBPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mbps next-cycle check failed");

// Next-cycle implication that also holds through reset.
`define MBPS_ASSERT_NEXT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("mbps reset check failed");

`endif

### hdl/mbps_pkg.sv
// Types and constants of the masked byte pattern search block.
package mbps_pkg;

  localparam int MAX_PATTERN_BYTES_DEF = 16;
  localparam int OFFSET_BITS_DEF       = 32;
  localparam int PATTERN_REG_BYTES     = 16;
  localparam int CFG_ADDR_W            = 6;
  localparam int CFG_DATA_W            = 64;

  localparam logic [63:0] ADDR_BAD_MARK   = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [15:0] CARE_RESET      = 16'hFFFF;
  localparam logic [4:0]  LENGTH_RESET    = 5'd1;

  typedef enum logic [2:0] {
    REG_PAT_LOW  = 3'd0,
    REG_PAT_HIGH = 3'd1,
    REG_CARE     = 3'd2,
    REG_LENGTH   = 3'd3,
    REG_BASE     = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] region_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [31:0] match_offset;
    logic [63:0] match_address;
  } out_item_t;

endpackage

### hdl/masked_byte_pattern_search_core.sv
// Masked byte pattern search: top level with window, compare and result register.
//
// Usage: region bytes enter one per item on the in_ channel (valid/stall);
// last_byte marks the final byte of a region. The block compares a sliding
// window of recent bytes with the configured pattern; a cleared care bit
// makes that pattern byte a wildcard. Each region yields exactly one result
// item on the out_ channel: the first match (offset and address), or a
// not-found item at the last byte. Bytes after a match give no result.
// Path: the input register holds an item, the result register its result.
// Throughput: one item per cycle unless a held result stalls out_; the window
// compare, offset subtract and address add sit between those two registers.
// Stall: a held result keeps the input register full, which raises in_stall
// in the same cycle; nothing is dropped. Reset (rst_n low, synchronous): both
// channels empty, region state cleared, registers to pattern 0, care bits all
// ones, length 1, base 0. The user must write registers through the APB port
// only while no item is in flight; the block itself does not enforce this.
module masked_byte_pattern_search_core #(
  parameter int MAX_PATTERN_BYTES = mbps_pkg::MAX_PATTERN_BYTES_DEF,
  parameter int OFFSET_BITS       = mbps_pkg::OFFSET_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  mbps_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output mbps_pkg::out_item_t           out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mbps_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [mbps_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [mbps_pkg::CFG_DATA_W-1:0] prdata,
  output logic                          pready
);

  // The window holds at most the sixteen pattern register bytes.
  localparam int WIN = (MAX_PATTERN_BYTES < mbps_pkg::PATTERN_REG_BYTES) ?
                       MAX_PATTERN_BYTES : mbps_pkg::PATTERN_REG_BYTES;
  localparam int IW  = (WIN > 1) ? $clog2(WIN) : 1;
  localparam int LW  = $clog2(WIN + 1);

  // configuration registers
  logic [63:0] pat_lo_r, pat_lo_nxt;
  logic [63:0] pat_hi_r, pat_hi_nxt;
  logic [15:0] care_r, care_nxt;
  logic [4:0]  len_r, len_nxt;
  logic [63:0] base_r, base_nxt;

  // channel and region state
  logic                   in_vld_r, in_vld_nxt;
  mbps_pkg::in_item_t     in_data_r;
  logic                   out_vld_r, out_vld_nxt;
  mbps_pkg::out_item_t    out_data_r, out_data_nxt;
  logic [7:0]             win_r [WIN];
  logic [7:0]             win_sh [WIN];
  logic [OFFSET_BITS-1:0] seen_r, seen_nxt;
  logic [LW-1:0]          fill_r, fill_nxt;
  logic                   rep_r, rep_nxt;

  logic                   in_acc;
  logic                   fire;
  logic                   win_we;
  logic                   cfg_wr;
  logic [2:0]             cfg_idx;
  logic [127:0]           pat_bytes;
  logic [LW-1:0]          len_eff;
  logic [LW-1:0]          fill_sh;
  logic                   all_ok;
  logic                   hit;
  logic [OFFSET_BITS-1:0] start;
  logic [63:0]            start64;

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;
  assign cfg_idx   = paddr[mbps_pkg::CFG_ADDR_W-1:3];
  assign pat_bytes = {pat_hi_r, pat_lo_r};

  // Advance the input register whenever the result register can take a new item.
  assign fire     = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !fire;
  assign in_acc   = in_valid && !in_stall;
  assign win_we   = fire && !rep_r;

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  // clamp the length to the window
  assign len_eff = (len_r > 5'(WIN)) ? LW'(WIN) : LW'(len_r);
  assign fill_sh = (fill_r == LW'(WIN)) ? fill_r : fill_r + LW'(1);
  assign start   = seen_r + OFFSET_BITS'(1) - OFFSET_BITS'(len_eff);
  assign start64 = 64'(start);

  always_comb begin
    logic [IW-1:0] pos;
    pos       = '0;
    win_sh[0] = in_data_r.region_byte;
    for (int k = 1; k < WIN; k++) begin
      win_sh[k] = win_r[k-1];
    end
    // Pattern byte i lines up with the byte that arrived len-1-i items ago.
    all_ok = 1'b1;
    for (int i = 0; i < WIN; i++) begin
      if (i < int'(len_eff)) begin
        pos = IW'(int'(len_eff) - 1 - i);
        if (care_r[i] && (pat_bytes[8*i +: 8] != win_sh[pos])) begin
          all_ok = 1'b0;
        end
      end
    end
  end

  assign hit = (len_eff != '0) && (base_r != mbps_pkg::ADDR_BAD_MARK) &&
               (fill_sh >= len_eff) && all_ok;

  always_comb begin
    pat_lo_nxt   = pat_lo_r;
    pat_hi_nxt   = pat_hi_r;
    care_nxt     = care_r;
    len_nxt      = len_r;
    base_nxt     = base_r;
    in_vld_nxt   = in_vld_r;
    out_vld_nxt  = out_vld_r && out_stall;
    out_data_nxt = out_data_r;
    seen_nxt     = seen_r;
    fill_nxt     = fill_r;
    rep_nxt      = rep_r;

    if (cfg_wr) begin
      case (mbps_pkg::cfg_reg_t'(cfg_idx))
        mbps_pkg::REG_PAT_LOW:  pat_lo_nxt = pwdata;
        mbps_pkg::REG_PAT_HIGH: pat_hi_nxt = pwdata;
        mbps_pkg::REG_CARE:     care_nxt   = pwdata[15:0];
        mbps_pkg::REG_LENGTH:   len_nxt    = pwdata[4:0];
        mbps_pkg::REG_BASE:     base_nxt   = pwdata;
        default: ;
      endcase
    end

    if (in_acc) begin
      in_vld_nxt = 1'b1;
    end else if (fire) begin
      in_vld_nxt = 1'b0;
    end

    if (fire) begin
      if (rep_r) begin
        // drop bytes after a match; the last one closes the region
        if (in_data_r.last_byte) begin
          seen_nxt = '0;
          fill_nxt = '0;
          rep_nxt  = 1'b0;
        end
      end else begin
        fill_nxt = fill_sh;
        if (hit) begin
          out_vld_nxt                = 1'b1;
          out_data_nxt.found         = 1'b1;
          out_data_nxt.match_offset  = start64[31:0];
          out_data_nxt.match_address = base_r + start64;
          if (in_data_r.last_byte) begin
            seen_nxt = '0;
            fill_nxt = '0;
          end else begin
            rep_nxt = 1'b1;
          end
        end else begin
          seen_nxt = seen_r + OFFSET_BITS'(1);
          if (in_data_r.last_byte) begin
            out_vld_nxt  = 1'b1;
            out_data_nxt = '0;
            seen_nxt     = '0;
            fill_nxt     = '0;
          end
        end
      end
    end
  end

  always_comb begin
    case (mbps_pkg::cfg_reg_t'(cfg_idx))
      mbps_pkg::REG_PAT_LOW:  prdata = pat_lo_r;
      mbps_pkg::REG_PAT_HIGH: prdata = pat_hi_r;
      mbps_pkg::REG_CARE:     prdata = 64'(care_r);
      mbps_pkg::REG_LENGTH:   prdata = 64'(len_r);
      mbps_pkg::REG_BASE:     prdata = base_r;
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r  <= '0;
      pat_hi_r  <= '0;
      care_r    <= mbps_pkg::CARE_RESET;
      len_r     <= mbps_pkg::LENGTH_RESET;
      base_r    <= '0;
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      seen_r    <= '0;
      fill_r    <= '0;
      rep_r     <= 1'b0;
    end else begin
      pat_lo_r  <= pat_lo_nxt;
      pat_hi_r  <= pat_hi_nxt;
      care_r    <= care_nxt;
      len_r     <= len_nxt;
      base_r    <= base_nxt;
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      seen_r    <= seen_nxt;
      fill_r    <= fill_nxt;
      rep_r     <= rep_nxt;
    end
  end

  // payload registers; window entries beyond the fill count are never compared
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_data_r <= in_data;
    end
    if (win_we) begin
      win_r <= win_sh;
    end
    out_data_r <= out_data_nxt;
  end

endmodule

### hdl/mbps_checker.sv
// Port-level checks for the masked byte pattern search block, bound to its top level.
`include "masked_byte_pattern_search_core_defines.svh"

module mbps_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input mbps_pkg::out_item_t out_data
);

  // reset empties the result register
  `MBPS_ASSERT_NEXT_RST(a_reset_empties, !rst_n, !out_valid)

  // a not-found item carries zero offset and address
  `MBPS_ASSERT_NOW(a_notfound_zero, out_valid && !out_data.found,
                   (out_data.match_offset == 32'd0) && (out_data.match_address == 64'd0))

  // the input side only stalls behind a held result
  `MBPS_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)

  // a held result stays put
  `MBPS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

endmodule

bind masked_byte_pattern_search_core mbps_checker u_mbps_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

### bench/tb_masked_byte_pattern_search_core.sv
// Self-checking bench for the masked byte pattern search core: predictor, stream and APB drivers.
module tb_masked_byte_pattern_search_core;

  localparam int CYCLE         = 12;
  localparam int WIN_BYTES     = 16;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_BYTES   = 135;
  localparam int DRAIN_CYCLES  = 6;
  localparam int LIMIT_CYCLES  = 400000;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  class search_scoreboard;
    logic [63:0] pat_lo;
    logic [63:0] pat_hi;
    logic [15:0] care;
    logic [4:0]  length;
    logic [63:0] base;
    logic [7:0]  window [WIN_BYTES];
    logic [31:0] bytes_seen;
    int          fill;
    bit          match_reported;
    mbps_pkg::out_item_t expected_q [$];
    int          errors;
    int          hits;
    int          misses;

    function new();
      pat_lo = '0;
      pat_hi = '0;
      care   = mbps_pkg::CARE_RESET;
      length = mbps_pkg::LENGTH_RESET;
      base   = '0;
      errors = 0;
      hits   = 0;
      misses = 0;
      end_region();
    endfunction

    function void end_region();
      foreach (window[i]) window[i] = '0;
      bytes_seen     = '0;
      fill           = 0;
      match_reported = 1'b0;
    endfunction

    function int active_length();
      return (length > WIN_BYTES) ? WIN_BYTES : int'(length);
    endfunction

    function logic [7:0] pattern_byte(int i);
      logic [127:0] pat;
      pat = {pat_hi, pat_lo};
      return pat[8*i +: 8];
    endfunction

    function void write_reg(mbps_pkg::cfg_reg_t r, logic [63:0] v);
      case (r)
        mbps_pkg::REG_PAT_LOW:  pat_lo = v;
        mbps_pkg::REG_PAT_HIGH: pat_hi = v;
        mbps_pkg::REG_CARE:     care   = v[15:0];
        mbps_pkg::REG_LENGTH:   length = v[4:0];
        mbps_pkg::REG_BASE:     base   = v;
        default: ;
      endcase
    endfunction

    function logic [63:0] read_reg(mbps_pkg::cfg_reg_t r);
      case (r)
        mbps_pkg::REG_PAT_LOW:  return pat_lo;
        mbps_pkg::REG_PAT_HIGH: return pat_hi;
        mbps_pkg::REG_CARE:     return {48'b0, care};
        mbps_pkg::REG_LENGTH:   return {59'b0, length};
        mbps_pkg::REG_BASE:     return base;
        default:                return '0;
      endcase
    endfunction

    // Returns 1 when the byte enters the window, 0 when the region already matched.
    function bit note_byte(mbps_pkg::in_item_t it);
      int          len;
      int          k;
      bit          hit;
      logic [31:0] start;
      mbps_pkg::out_item_t res;
      if (match_reported) begin
        if (it.last_byte) end_region();
        return 1'b0;
      end
      for (k = WIN_BYTES - 1; k > 0; k--) window[k] = window[k-1];
      window[0] = it.region_byte;
      if (fill < WIN_BYTES) fill++;
      len = active_length();
      hit = (len != 0) && (base != mbps_pkg::ADDR_BAD_MARK) && (fill >= len);
      // oldest window byte lines up with pattern byte 0
      for (k = 0; k < len; k++) begin
        if (care[k] && pattern_byte(k) != window[len-1-k]) hit = 1'b0;
      end
      if (hit) begin
        start             = bytes_seen + 32'd1 - 32'(len);
        res.found         = 1'b1;
        res.match_offset  = start;
        res.match_address = base + {32'b0, start};
        expected_q.push_back(res);
        if (it.last_byte) end_region();
        else match_reported = 1'b1;
        return 1'b1;
      end
      bytes_seen++;
      if (it.last_byte) begin
        res = '0;
        expected_q.push_back(res);
        end_region();
      end
      return 1'b1;
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(mbps_pkg::out_item_t got);
      mbps_pkg::out_item_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result found=%0b offset=%0h address=%0h",
                         got.found, got.match_offset, got.match_address));
        return;
      end
      want = expected_q.pop_front();
      if (got.found !== want.found)
        report($sformatf("found got %0b want %0b", got.found, want.found));
      if (got.match_offset !== want.match_offset)
        report($sformatf("offset got %0h want %0h", got.match_offset, want.match_offset));
      if (got.match_address !== want.match_address)
        report($sformatf("address got %0h want %0h", got.match_address, want.match_address));
      if (want.found) hits++;
      else misses++;
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_stall;
  mbps_pkg::in_item_t              in_data;
  logic                            out_valid;
  logic                            out_stall;
  mbps_pkg::out_item_t             out_data;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [mbps_pkg::CFG_ADDR_W-1:0] paddr;
  logic [mbps_pkg::CFG_DATA_W-1:0] pwdata;
  logic [mbps_pkg::CFG_DATA_W-1:0] prdata;
  logic                            pready;

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int bytes_sent   = 0;
  int regions_sent = 0;
  int cfg_writes   = 0;

  search_scoreboard sb;

  masked_byte_pattern_search_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    clk = 1'b0;
    #(CYCLE / 2);
    clk = 1'b1;
    #(CYCLE / 2);
  end

  always @(posedge clk) begin
    out_stall <= (rx_stall_pct != 0) && ($urandom_range(99) < rx_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  initial begin
    #(CYCLE * LIMIT_CYCLES);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_byte(mbps_pkg::in_item_t it);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    void'(sb.note_byte(it));
    bytes_sent++;
    if (it.last_byte) regions_sent++;
  endtask

  task automatic send_region(logic [7:0] bytes_q [$], bit closed);
    mbps_pkg::in_item_t it;
    for (int k = 0; k < bytes_q.size(); k++) begin
      it.region_byte = bytes_q[k];
      it.last_byte   = closed && (k == bytes_q.size() - 1);
      send_byte(it);
    end
  endtask

  // Region of noise with one planted occurrence most of the time; some run past the end.
  task automatic send_random_region(bit closed);
    logic [7:0] bytes_q [$];
    int         len;
    int         rlen;
    int         at;
    int         k;
    bit         near;
    len  = sb.active_length();
    rlen = ($urandom_range(7) == 0) ? $urandom_range(60, 1) : $urandom_range(len + 8, 1);
    near = $urandom_range(1);
    for (k = 0; k < rlen; k++) begin
      if (near && len != 0 && $urandom_range(1))
        bytes_q.push_back(sb.pattern_byte($urandom_range(len - 1)));
      else
        bytes_q.push_back(8'($urandom));
    end
    if (len != 0 && $urandom_range(9) < 7) begin
      if (rlen >= len && $urandom_range(3) != 0) at = $urandom_range(rlen - len);
      else at = $urandom_range(rlen - 1);
      for (k = 0; k < len && at + k < rlen; k++) begin
        if (sb.care[k]) bytes_q[at+k] = sb.pattern_byte(k);
      end
    end
    send_region(bytes_q, closed);
  endtask

  task automatic drain(int extra);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic cfg_write(mbps_pkg::cfg_reg_t r, logic [63:0] v);
    logic [63:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= mbps_pkg::CFG_ADDR_W'(8 * int'(r));
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.write_reg(r, v);
    cfg_writes++;
    @(posedge clk);
    // read back the same register
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== sb.read_reg(r))
      sb.report($sformatf("register %s reads %0h want %0h", r.name(), rd, sb.read_reg(r)));
    @(posedge clk);
  endtask

  task automatic set_search(logic [63:0] lo, logic [63:0] hi, logic [15:0] care,
                            logic [4:0] len, logic [63:0] base);
    cfg_write(mbps_pkg::REG_PAT_LOW, lo);
    cfg_write(mbps_pkg::REG_PAT_HIGH, hi);
    cfg_write(mbps_pkg::REG_CARE, {48'b0, care});
    cfg_write(mbps_pkg::REG_LENGTH, {59'b0, len});
    cfg_write(mbps_pkg::REG_BASE, base);
  endtask

  initial begin
    logic [7:0]  region [$];
    idle_mode_t  mode;
    logic [15:0] care;
    logic [4:0]  len;
    logic [63:0] base;
    int          phase;
    int          phase_start;
    int          pause_at;
    bit          paused;
    sb = new();
    rst_n   <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    out_stall <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: one exact byte 0x00; match mid-region, then ignored last byte
    region = {8'h00, 8'hFF};
    send_region(region, 1'b1);
    region = {8'hFF, 8'h80};
    send_region(region, 1'b1);
    drain(DRAIN_CYCLES);

    // 41 42 ?? 44 near the top of the address space: match on the last byte, address wraps
    set_search(64'h0000_0000_4400_4241, 64'h0, 16'hFFFB, 5'd4, 64'hFFFF_FFFF_FFFF_FFFE);
    region = {8'h00, 8'h41, 8'h41, 8'h42, 8'h7F, 8'h44};
    send_region(region, 1'b1);
    // pattern would reach past the last byte
    region = {8'h41, 8'h42, 8'h00};
    send_region(region, 1'b1);
    drain(DRAIN_CYCLES);

    cfg_write(mbps_pkg::REG_LENGTH, 64'd0);
    region = {8'h41};
    send_region(region, 1'b1);
    drain(DRAIN_CYCLES);

    // change the care bits halfway through a region; the window is kept
    cfg_write(mbps_pkg::REG_LENGTH, 64'd4);
    cfg_write(mbps_pkg::REG_BASE, 64'h1000);
    region = {8'h41, 8'h42};
    send_region(region, 1'b0);
    drain(DRAIN_CYCLES);
    cfg_write(mbps_pkg::REG_CARE, 64'hFFF0);
    region = {8'h00, 8'h00};
    send_region(region, 1'b1);
    drain(DRAIN_CYCLES);

    // bad base address never matches
    cfg_write(mbps_pkg::REG_CARE, {48'b0, mbps_pkg::CARE_RESET});
    cfg_write(mbps_pkg::REG_LENGTH, 64'd1);
    cfg_write(mbps_pkg::REG_BASE, mbps_pkg::ADDR_BAD_MARK);
    region = {8'h41};
    send_region(region, 1'b1);
    drain(DRAIN_CYCLES);

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      mode = idle_mode_t'(phase % 4);
      case (mode)
        IDLE_NONE:     begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        IDLE_SENDER:   begin tx_idle_pct = 81; rx_stall_pct = 0;  end
        IDLE_RECEIVER: begin tx_idle_pct = 0;  rx_stall_pct = 81; end
        IDLE_BOTH:     begin tx_idle_pct = 6;  rx_stall_pct = 6;  end
        default: ;
      endcase
      care = 16'($urandom | $urandom);
      if ($urandom_range(3) == 0) len = 5'($urandom_range(16, 1));
      else len = 5'($urandom_range(6, 1));
      if ($urandom_range(9) == 0) len = 5'($urandom_range(31, 17));
      base = {$urandom, $urandom};
      case (phase)
        0: begin care = 16'hFFFF; len = 5'd16; base = '0; end
        1: begin care = 16'($urandom & $urandom); len = 5'd31; end
        2: len = 5'd0;
        3: begin care = 16'h0000; len = 5'd1; end
        4: base = mbps_pkg::ADDR_BAD_MARK;
        5: base = 64'hFFFF_FFFF_FFFF_FFF8;
        default: ;
      endcase
      set_search({$urandom, $urandom}, {$urandom, $urandom}, care, len, base);
      phase_start = bytes_sent;
      pause_at    = phase_start + $urandom_range(PHASE_BYTES - 20, 20);
      paused      = 1'b0;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        send_random_region(1'b1);
        if (!paused && bytes_sent >= pause_at) begin
          // hold the sender until every result is back
          drain(1);
          paused = 1'b1;
        end
      end
      // leave a region open now and then so the next settings land mid-region
      if ($urandom_range(1)) send_random_region(1'b0);
      drain(DRAIN_CYCLES);
    end

    drain(4 * DRAIN_CYCLES);
    $display("Sent %0d bytes in %0d regions, %0d register writes with read-back.",
             bytes_sent, regions_sent, cfg_writes);
    $display("Checked %0d match results and %0d not-found results under four idle modes.",
             sb.hits, sb.misses);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/mbps_pkg.sv
hdl/masked_byte_pattern_search_core.sv
hdl/mbps_checker.sv
bench/tb_masked_byte_pattern_search_core.sv
